[src/rss_pkg.sv]
// shared types and constants of the ray sphere shade unit
package rss_pkg;

   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

   localparam logic signed [15:0] CENTER_Z_RESET = -16'sd4096;
   localparam logic [14:0]        RADIUS_RESET   = 15'd2048;

   localparam int BYTE_SCALE = 25599;
   localparam int DEN_HIT    = 200;
   localparam int DEN_RED    = 400;
   localparam int DEN_GREEN  = 2000;
   localparam int NORM_TOP   = 29;

   localparam logic [7:0] DEGEN_BYTE = 8'd127;
   localparam logic [7:0] SKY_BLUE   = 8'd255;

endpackage

[src/rss_sqrt_pipe.sv]
// pipelined floor square root, one result bit per stage, with sideband
module rss_sqrt_pipe #(
   parameter int IN_W = 62,
   parameter int SB_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                up_valid,
   input  logic [IN_W-1:0]     up_radicand,
   input  logic [SB_W-1:0]     up_side,
   output logic                dn_valid,
   output logic [IN_W/2-1:0]   dn_root,
   output logic [SB_W-1:0]     dn_side
);

   localparam int STAGES = IN_W / 2;

   logic              v_ff   [STAGES];
   logic [IN_W-1:0]   rem_ff [STAGES];
   logic [IN_W-1:0]   res_ff [STAGES];
   logic [SB_W-1:0]   sb_ff  [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam logic [IN_W-1:0] BIT = {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2 * k);
      logic            v_cur;
      logic [IN_W-1:0] rem_cur, res_cur, trial, rem_in, res_in;
      logic [SB_W-1:0] sb_cur;

      if (k == 0) begin : g_first
         assign v_cur   = up_valid;
         assign rem_cur = up_radicand;
         assign res_cur = '0;
         assign sb_cur  = up_side;
      end else begin : g_next
         assign v_cur   = v_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign res_cur = res_ff[k-1];
         assign sb_cur  = sb_ff[k-1];
      end

      always_comb begin
         trial = res_cur + BIT;
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            res_in = (res_cur >> 1) + BIT;
         end else begin
            rem_in = rem_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
            sb_ff[k]  <= sb_cur;
         end
      end
   end

   assign dn_valid = v_ff[STAGES-1];
   assign dn_root  = res_ff[STAGES-1][STAGES-1:0];
   assign dn_side  = sb_ff[STAGES-1];

endmodule

[src/rss_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage, several lanes
module rss_div_pipe #(
   parameter int LANES = 1,
   parameter int NUM_W = 47,
   parameter int DEN_W = 32,
   parameter int Q_W   = 16,
   parameter int SB_W  = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              up_valid,
   input  logic [NUM_W-1:0]  up_num [LANES],
   input  logic [DEN_W-1:0]  up_den [LANES],
   input  logic [SB_W-1:0]   up_side,
   output logic              dn_valid,
   output logic [Q_W-1:0]    dn_quot [LANES],
   output logic [SB_W-1:0]   dn_side
);

   localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic              v_ff   [Q_W];
   logic [W-1:0]      rem_ff [Q_W][LANES];
   logic [DEN_W-1:0]  den_ff [Q_W][LANES];
   logic [Q_W-1:0]    q_ff   [Q_W][LANES];
   logic [SB_W-1:0]   sb_ff  [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int SH = Q_W - 1 - k;
      logic            v_cur;
      logic [SB_W-1:0] sb_cur;

      if (k == 0) begin : g_vfirst
         assign v_cur  = up_valid;
         assign sb_cur = up_side;
      end else begin : g_vnext
         assign v_cur  = v_ff[k-1];
         assign sb_cur = sb_ff[k-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [W-1:0]     rem_cur, rem_in, shifted;
         logic [DEN_W-1:0] den_cur;
         logic [Q_W-1:0]   q_cur, q_in;

         if (k == 0) begin : g_first
            assign rem_cur = W'(up_num[l]);
            assign den_cur = up_den[l];
            assign q_cur   = '0;
         end else begin : g_next
            assign rem_cur = rem_ff[k-1][l];
            assign den_cur = den_ff[k-1][l];
            assign q_cur   = q_ff[k-1][l];
         end

         always_comb begin
            shifted = W'(den_cur) << SH;
            q_in    = q_cur;
            if (rem_cur >= shifted) begin
               rem_in   = rem_cur - shifted;
               q_in[SH] = 1'b1;
            end else begin
               rem_in = rem_cur;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k][l] <= rem_in;
               den_ff[k][l] <= den_cur;
               q_ff[k][l]   <= q_in;
            end
         end

         if (k == Q_W - 1) begin : g_out
            assign dn_quot[l] = q_ff[k][l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sb_ff[k] <= sb_cur;
         end
      end
   end

   assign dn_valid = v_ff[Q_W-1];
   assign dn_side  = sb_ff[Q_W-1];

endmodule

[src/ray_sphere_shade_unit.sv]
// ray sphere intersection with normal shading and sky gradient, top level
//
// channel   dir   handshake              payload
// req       in    req_tvalid/tready      origin xyz, direction xyz
// rsp       out   rsp_tvalid/tready      red, green, blue, hit_distance; tuser hit
// csr       in    csr_we                 csr_addr, csr_wdata
//
// one ray per cycle while rsp is not stalled; the path runs through the two root pipes
// (34 and 31 stages) and the distance and channel dividers (16 and 8 stages)
// synchronous active high reset clears valid bits and loads register defaults
// a stall on rsp holds every stage in place; req_tready drops with it
module ray_sphere_shade_unit
   import rss_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red, green, blue, hit_distance
   output logic [39:0] rsp_tdata,
   // hit
   output logic        rsp_tuser
);

   localparam int TD_NUM_W = 35 + COORD_FRAC_BITS;

   typedef struct packed {
      logic [31:0]          a;
      logic signed [33:0]   h;
      logic [2:0][16:0]     oc;
      logic [2:0][15:0]     d;
      logic                 ok;
   } sb_root_type;

   typedef struct packed {
      logic [31:0]          a;
      logic signed [35:0]   num;
      logic [2:0][16:0]     oc;
      logic [2:0][15:0]     d;
      logic                 hit;
      logic                 sat;
   } sb_td_type;

   typedef struct packed {
      logic                 hit;
      logic                 anz;
      logic signed [15:0]   dy;
      logic [2:0]           neg;
      logic [2:0][29:0]     mgn;
      logic                 mxz;
      logic [15:0]          td;
   } sb_len_type;

   typedef struct packed {
      logic                 hit;
      logic                 mxz;
      logic [15:0]          td;
   } sb_chan_type;

   logic rsp_tvalid_ff;
   logic en;
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // configuration registers
   logic signed [15:0] cx_ff, cy_ff, cz_ff;
   logic [14:0]        rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         cz_ff  <= CENTER_Z_RESET;
         rad_ff <= RADIUS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_CENTER_X: cx_ff  <= csr_wdata;
            CSR_CENTER_Y: cy_ff  <= csr_wdata;
            CSR_CENTER_Z: cz_ff  <= csr_wdata;
            CSR_RADIUS:   rad_ff <= csr_wdata[14:0];
            default:      cx_ff  <= cx_ff;
         endcase
      end
   end

   // stage 1: offsets from center
   logic signed [15:0] org [3];
   logic signed [15:0] dir [3];
   logic signed [15:0] cen [3];
   assign org[0] = req_tdata[15:0];
   assign org[1] = req_tdata[31:16];
   assign org[2] = req_tdata[47:32];
   assign dir[0] = req_tdata[63:48];
   assign dir[1] = req_tdata[79:64];
   assign dir[2] = req_tdata[95:80];
   assign cen[0] = cx_ff;
   assign cen[1] = cy_ff;
   assign cen[2] = cz_ff;

   logic               v1_ff;
   logic signed [16:0] oc1_ff [3];
   logic signed [15:0] d1_ff  [3];
   logic [29:0]        r2_1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            oc1_ff[i] <= 17'(org[i]) - 17'(cen[i]);
            d1_ff[i]  <= dir[i];
         end
         r2_1_ff <= {15'b0, rad_ff} * {15'b0, rad_ff};
      end
   end

   // stage 2: products
   logic               v2_ff;
   logic [30:0]        dd2_ff [3];
   logic signed [31:0] od2_ff [3];
   logic [31:0]        oo2_ff [3];
   logic signed [16:0] oc2_ff [3];
   logic signed [15:0] d2_ff  [3];
   logic [29:0]        r2_2_ff;
   logic signed [31:0] dd2_in [3];
   logic signed [33:0] oo2_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd2_in[i] = 32'(d1_ff[i]) * 32'(d1_ff[i]);
         oo2_in[i] = 34'(oc1_ff[i]) * 34'(oc1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dd2_ff[i] <= dd2_in[i][30:0];
            od2_ff[i] <= 32'(oc1_ff[i]) * 32'(d1_ff[i]);
            oo2_ff[i] <= oo2_in[i][31:0];
            oc2_ff[i] <= oc1_ff[i];
            d2_ff[i]  <= d1_ff[i];
         end
         r2_2_ff <= r2_1_ff;
      end
   end

   // stage 3: dot products
   logic               v3_ff;
   logic [31:0]        a3_ff;
   logic signed [33:0] h3_ff;
   logic signed [34:0] cc3_ff;
   logic signed [16:0] oc3_ff [3];
   logic signed [15:0] d3_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a3_ff  <= 32'(dd2_ff[0]) + 32'(dd2_ff[1]) + 32'(dd2_ff[2]);
         h3_ff  <= 34'(od2_ff[0]) + 34'(od2_ff[1]) + 34'(od2_ff[2]);
         cc3_ff <= $signed({3'b0, oo2_ff[0]}) + $signed({3'b0, oo2_ff[1]})
                 + $signed({3'b0, oo2_ff[2]}) - $signed({5'b0, r2_2_ff});
         oc3_ff <= oc2_ff;
         d3_ff  <= d2_ff;
      end
   end

   // stage 4: h squared and a times c
   logic               v4_ff;
   logic [65:0]        hh4_ff, ac4_ff;
   logic               cle4_ff;
   logic [31:0]        a4_ff;
   logic signed [33:0] h4_ff;
   logic signed [16:0] oc4_ff [3];
   logic signed [15:0] d4_ff  [3];
   logic [32:0]        hmag;
   logic [33:0]        ccmag;
   logic signed [33:0] hneg;
   logic signed [34:0] ccneg;

   always_comb begin
      hneg  = -h3_ff;
      ccneg = -cc3_ff;
      hmag  = h3_ff[33]  ? hneg[32:0]  : h3_ff[32:0];
      ccmag = cc3_ff[34] ? ccneg[33:0] : cc3_ff[33:0];
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh4_ff  <= 66'(hmag) * 66'(hmag);
         ac4_ff  <= 66'(a3_ff) * 66'(ccmag);
         cle4_ff <= cc3_ff[34] || (cc3_ff == '0);
         a4_ff   <= a3_ff;
         h4_ff   <= h3_ff;
         oc4_ff  <= oc3_ff;
         d4_ff   <= d3_ff;
      end
   end

   // stage 5: discriminant
   logic        v5_ff;
   logic [67:0] disc5_ff;
   sb_root_type sb5_ff, sb5_in;

   always_comb begin
      sb5_in.a  = a4_ff;
      sb5_in.h  = h4_ff;
      for (int i = 0; i < 3; i++) begin
         sb5_in.oc[i] = oc4_ff[i];
         sb5_in.d[i]  = d4_ff[i];
      end
      sb5_in.ok = cle4_ff || (ac4_ff <= hh4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (en) v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         priority if (cle4_ff) disc5_ff <= 68'(hh4_ff) + 68'(ac4_ff);
         else if (ac4_ff <= hh4_ff) disc5_ff <= 68'(hh4_ff - ac4_ff);
         else disc5_ff <= 68'(hh4_ff);
         sb5_ff <= sb5_in;
      end
   end

   // discriminant root
   logic        vr_out;
   logic [33:0] root_s;
   logic [$bits(sb_root_type)-1:0] sbr_vec;
   sb_root_type sbr;

   rss_sqrt_pipe #(.IN_W(68), .SB_W($bits(sb_root_type))) u_disc_root (
      .clock(clock), .reset(reset), .en(en),
      .up_valid(v5_ff), .up_radicand(disc5_ff), .up_side(sb5_ff),
      .dn_valid(vr_out), .dn_root(root_s), .dn_side(sbr_vec)
   );
   assign sbr = sbr_vec;

   // stage 6: nearest root numerator and distance operands
   logic                v6_ff;
   logic [TD_NUM_W-1:0] tdn6_ff;
   logic [31:0]         tdd6_ff;
   sb_td_type           sb6_ff, sb6_in;
   logic [TD_NUM_W-1:0] tdn_full;

   always_comb begin
      sb6_in.a   = sbr.a;
      sb6_in.num = -36'(sbr.h) - 36'({2'b0, root_s});
      sb6_in.oc  = sbr.oc;
      sb6_in.d   = sbr.d;
      sb6_in.hit = sbr.ok && (sbr.a != '0) && !sb6_in.num[35] && (sb6_in.num != '0);
      tdn_full   = {sb6_in.num[34:0], {COORD_FRAC_BITS{1'b0}}};
      sb6_in.sat = 64'(tdn_full) >= 64'({sbr.a, 16'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (en) v6_ff <= vr_out;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tdn6_ff <= sb6_in.hit ? tdn_full : '0;
         tdd6_ff <= (sbr.a == '0) ? 32'd1 : sbr.a;
         sb6_ff  <= sb6_in;
      end
   end

   // hit distance division
   logic                vt_out;
   logic [TD_NUM_W-1:0] tdn_arr [1];
   logic [31:0]         tdd_arr [1];
   logic [15:0]         tq_arr  [1];
   logic [$bits(sb_td_type)-1:0] sbt_vec;
   sb_td_type           sbt;

   assign tdn_arr[0] = tdn6_ff;
   assign tdd_arr[0] = tdd6_ff;

   rss_div_pipe #(.LANES(1), .NUM_W(TD_NUM_W), .DEN_W(32), .Q_W(16),
                  .SB_W($bits(sb_td_type))) u_dist_div (
      .clock(clock), .reset(reset), .en(en),
      .up_valid(v6_ff), .up_num(tdn_arr), .up_den(tdd_arr), .up_side(sb6_ff),
      .dn_valid(vt_out), .dn_quot(tq_arr), .dn_side(sbt_vec)
   );
   assign sbt = sbt_vec;

   // stage 7: normal products
   logic               v7_ff;
   logic signed [49:0] pa7_ff [3];
   logic signed [51:0] pn7_ff [3];
   logic               hit7_ff;
   logic [31:0]        a7_ff;
   logic signed [15:0] dy7_ff;
   logic [15:0]        td7_ff;

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (en) v7_ff <= vt_out;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pa7_ff[i] <= 50'($signed(sbt.oc[i])) * $signed({18'b0, sbt.a});
            pn7_ff[i] <= 52'($signed(sbt.num)) * 52'($signed(sbt.d[i]));
         end
         hit7_ff <= sbt.hit;
         a7_ff   <= sbt.a;
         dy7_ff  <= $signed(sbt.d[1]);
         td7_ff  <= !sbt.hit ? 16'd0 : (sbt.sat ? 16'hFFFF : tq_arr[0]);
      end
   end

   // stage 8: normal vector magnitudes
   logic               v8_ff;
   logic [52:0]        mg8_ff [3];
   logic [2:0]         neg8_ff;
   logic               hit8_ff;
   logic [31:0]        a8_ff;
   logic signed [15:0] dy8_ff;
   logic [15:0]        td8_ff;
   logic signed [52:0] msum [3];
   logic signed [52:0] mneg [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         msum[i] = 53'(pa7_ff[i]) + 53'(pn7_ff[i]);
         mneg[i] = -msum[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (en) v8_ff <= v7_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg8_ff[i] <= msum[i][52];
            mg8_ff[i]  <= msum[i][52] ? mneg[i] : msum[i];
         end
         hit8_ff <= hit7_ff;
         a8_ff   <= a7_ff;
         dy8_ff  <= dy7_ff;
         td8_ff  <= td7_ff;
      end
   end

   // stage 9: largest magnitude
   logic               v9_ff;
   logic [52:0]        mx9_ff;
   logic [52:0]        mg9_ff [3];
   logic [2:0]         neg9_ff;
   logic               hit9_ff;
   logic [31:0]        a9_ff;
   logic signed [15:0] dy9_ff;
   logic [15:0]        td9_ff;
   logic [52:0]        mx01;

   assign mx01 = (mg8_ff[1] > mg8_ff[0]) ? mg8_ff[1] : mg8_ff[0];

   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else if (en) v9_ff <= v8_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx9_ff  <= (mg8_ff[2] > mx01) ? mg8_ff[2] : mx01;
         mg9_ff  <= mg8_ff;
         neg9_ff <= neg8_ff;
         hit9_ff <= hit8_ff;
         a9_ff   <= a8_ff;
         dy9_ff  <= dy8_ff;
         td9_ff  <= td8_ff;
      end
   end

   // stage 10: leading one of the largest magnitude
   logic               v10_ff;
   logic [5:0]         lead10_ff;
   logic               mxz10_ff;
   logic [52:0]        mg10_ff [3];
   logic [2:0]         neg10_ff;
   logic               hit10_ff;
   logic [31:0]        a10_ff;
   logic signed [15:0] dy10_ff;
   logic [15:0]        td10_ff;
   logic [5:0]         lead_in;

   always_comb begin
      lead_in = '0;
      for (int b = 0; b < 53; b++) begin
         if (mx9_ff[b]) lead_in = 6'(b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v10_ff <= 1'b0;
      else if (en) v10_ff <= v9_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lead10_ff <= lead_in;
         mxz10_ff  <= (mx9_ff == '0);
         mg10_ff   <= mg9_ff;
         neg10_ff  <= neg9_ff;
         hit10_ff  <= hit9_ff;
         a10_ff    <= a9_ff;
         dy10_ff   <= dy9_ff;
         td10_ff   <= td9_ff;
      end
   end

   // stage 11: normalize magnitudes
   logic               v11_ff;
   logic [29:0]        mgn11_ff [3];
   logic               mxz11_ff;
   logic [2:0]         neg11_ff;
   logic               hit11_ff;
   logic [31:0]        a11_ff;
   logic signed [15:0] dy11_ff;
   logic [15:0]        td11_ff;
   logic [52:0]        mshift [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (lead10_ff > 6'(NORM_TOP)) mshift[i] = mg10_ff[i] >> (lead10_ff - 6'(NORM_TOP));
         else mshift[i] = mg10_ff[i] << (6'(NORM_TOP) - lead10_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v11_ff <= 1'b0;
      else if (en) v11_ff <= v10_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) mgn11_ff[i] <= mshift[i][29:0];
         mxz11_ff <= mxz10_ff;
         neg11_ff <= neg10_ff;
         hit11_ff <= hit10_ff;
         a11_ff   <= a10_ff;
         dy11_ff  <= dy10_ff;
         td11_ff  <= td10_ff;
      end
   end

   // stage 12: squares
   logic               v12_ff;
   logic [59:0]        sq12_ff [3];
   logic [29:0]        mgn12_ff [3];
   logic               mxz12_ff;
   logic [2:0]         neg12_ff;
   logic               hit12_ff;
   logic [31:0]        a12_ff;
   logic signed [15:0] dy12_ff;
   logic [15:0]        td12_ff;

   always_ff @(posedge clock) begin
      if (reset) v12_ff <= 1'b0;
      else if (en) v12_ff <= v11_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) sq12_ff[i] <= 60'(mgn11_ff[i]) * 60'(mgn11_ff[i]);
         mgn12_ff <= mgn11_ff;
         mxz12_ff <= mxz11_ff;
         neg12_ff <= neg11_ff;
         hit12_ff <= hit11_ff;
         a12_ff   <= a11_ff;
         dy12_ff  <= dy11_ff;
         td12_ff  <= td11_ff;
      end
   end

   // stage 13: length radicand, normal or sky
   logic        v13_ff;
   logic [61:0] rad13_ff;
   sb_len_type  sb13_ff, sb13_in;
   logic [61:0] sqsum;

   always_comb begin
      sqsum       = 62'(sq12_ff[0]) + 62'(sq12_ff[1]) + 62'(sq12_ff[2]);
      sb13_in.hit = hit12_ff;
      sb13_in.anz = (a12_ff != '0);
      sb13_in.dy  = dy12_ff;
      sb13_in.neg = neg12_ff;
      for (int i = 0; i < 3; i++) sb13_in.mgn[i] = mgn12_ff[i];
      sb13_in.mxz = mxz12_ff;
      sb13_in.td  = td12_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) v13_ff <= 1'b0;
      else if (en) v13_ff <= v12_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad13_ff <= hit12_ff ? sqsum : {a12_ff, 30'b0};
         sb13_ff  <= sb13_in;
      end
   end

   // length root
   logic        vl_out;
   logic [30:0] len_root;
   logic [$bits(sb_len_type)-1:0] sbl_vec;
   sb_len_type  sbl;

   rss_sqrt_pipe #(.IN_W(62), .SB_W($bits(sb_len_type))) u_len_root (
      .clock(clock), .reset(reset), .en(en),
      .up_valid(v13_ff), .up_radicand(rad13_ff), .up_side(sb13_ff),
      .dn_valid(vl_out), .dn_root(len_root), .dn_side(sbl_vec)
   );
   assign sbl = sbl_vec;

   // stage 14: channel values
   logic               v14_ff;
   logic [35:0]        val14_ff [3];
   logic [30:0]        len14_ff;
   sb_chan_type        sb14_ff, sb14_in;
   logic [30:0]        len_m;
   logic signed [32:0] yv, ylim, yc;
   logic signed [36:0] lsx, ysx, rv, gv;
   logic [31:0]        lw, mw;
   logic [35:0]        val_in [3];

   always_comb begin
      len_m = (!sbl.hit && !sbl.anz) ? 31'd1 : len_root;
      yv    = 33'($signed({sbl.dy, 15'b0}));
      ylim  = $signed({2'b0, len_m});
      priority if (yv > ylim) yc = ylim;
      else if (yv < -ylim) yc = -ylim;
      else yc = yv;
      lsx = $signed({6'b0, len_m});
      ysx = 37'(yc);
      rv  = 3 * lsx - ysx;
      gv  = 17 * lsx - 3 * ysx;
      lw  = {1'b0, len_m};
      for (int i = 0; i < 3; i++) begin
         mw = {2'b0, sbl.mgn[i]};
         if (sbl.neg[i]) val_in[i] = (mw >= lw) ? 36'd0 : 36'(lw - mw);
         else val_in[i] = 36'(lw) + 36'((mw > lw) ? lw : mw);
      end
      if (!sbl.hit) begin
         val_in[0] = rv[35:0];
         val_in[1] = gv[35:0];
         val_in[2] = '0;
      end
      sb14_in.hit = sbl.hit;
      sb14_in.mxz = sbl.mxz;
      sb14_in.td  = sbl.td;
   end

   always_ff @(posedge clock) begin
      if (reset) v14_ff <= 1'b0;
      else if (en) v14_ff <= vl_out;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val14_ff <= val_in;
         len14_ff <= len_m;
         sb14_ff  <= sb14_in;
      end
   end

   // stage 15: byte dividends and divisors
   logic        v15_ff;
   logic [50:0] num15_ff [3];
   logic [41:0] den15_ff [3];
   sb_chan_type sb15_ff;

   always_ff @(posedge clock) begin
      if (reset) v15_ff <= 1'b0;
      else if (en) v15_ff <= v14_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) num15_ff[i] <= 51'(val14_ff[i]) * 51'(BYTE_SCALE);
         den15_ff[0] <= 42'(len14_ff) * 42'(sb14_ff.hit ? DEN_HIT : DEN_RED);
         den15_ff[1] <= 42'(len14_ff) * 42'(sb14_ff.hit ? DEN_HIT : DEN_GREEN);
         den15_ff[2] <= 42'(len14_ff) * 42'(DEN_HIT);
         sb15_ff     <= sb14_ff;
      end
   end

   // channel division
   logic        vc_out;
   logic [7:0]  cq [3];
   logic [$bits(sb_chan_type)-1:0] sbc_vec;
   sb_chan_type sbc;

   rss_div_pipe #(.LANES(3), .NUM_W(51), .DEN_W(42), .Q_W(8),
                  .SB_W($bits(sb_chan_type))) u_chan_div (
      .clock(clock), .reset(reset), .en(en),
      .up_valid(v15_ff), .up_num(num15_ff), .up_den(den15_ff), .up_side(sb15_ff),
      .dn_valid(vc_out), .dn_quot(cq), .dn_side(sbc_vec)
   );
   assign sbc = sbc_vec;

   // output register
   logic [39:0] rsp_data_ff, rsp_data_in;
   logic        rsp_hit_ff;
   logic        degen;

   always_comb begin
      degen              = sbc.hit && sbc.mxz;
      rsp_data_in[7:0]   = degen ? DEGEN_BYTE : cq[0];
      rsp_data_in[15:8]  = degen ? DEGEN_BYTE : cq[1];
      rsp_data_in[23:16] = !sbc.hit ? SKY_BLUE : (degen ? DEGEN_BYTE : cq[2]);
      rsp_data_in[39:24] = sbc.td;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else if (en) rsp_tvalid_ff <= vc_out;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_hit_ff  <= sbc.hit;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

endmodule

[verif/tb_ray_sphere_shade_unit.sv]
// self-checking testbench for the ray sphere shade unit: predicts every shaded beat
module tb_ray_sphere_shade_unit;
   import rss_pkg::*;

   localparam int FRAC = 12;
   localparam int LATENCY = 105;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [15:0] o[3];
      logic signed [15:0] d[3];
   } ray_type;

   typedef struct {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        hit;
      logic [15:0] distance;
   } shade_type;

   class shade_scoreboard;
      shade_type expected_q[$];
      logic signed [15:0] center[3];
      logic [14:0] radius;
      int errors;

      function new();
         center[0] = 0;
         center[1] = 0;
         center[2] = CENTER_Z_RESET;
         radius = RADIUS_RESET;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_CENTER_X: center[0] = value;
            CSR_CENTER_Y: center[1] = value;
            CSR_CENTER_Z: center[2] = value;
            CSR_RADIUS: radius = value[14:0];
         endcase
      endfunction

      function longint unsigned root_floor(bit [127:0] x, int top);
         longint unsigned s, cand;
         s = 0;
         for (int b = top; b >= 0; b--) begin
            cand = s | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= x) s = cand;
         end
         return s;
      endfunction

      function logic [7:0] to_byte(longint unsigned num, longint unsigned den);
         longint unsigned q;
         q = num / den;
         return q > 255 ? 8'd255 : q[7:0];
      endfunction

      function longint unsigned mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      function void note(ray_type r);
         longint oc[3], d[3], a, h, cc, rr, num, m, yv, lv;
         bit [127:0] hh, ac, disc;
         longint unsigned s, mg[3], mx, len, sum, td, val;
         bit neg[3], ok, done;
         shade_type e;
         a = 0; h = 0; cc = 0; done = 0;
         rr = radius;
         for (int i = 0; i < 3; i++) begin
            oc[i] = longint'(r.o[i]) - longint'(center[i]);
            d[i] = r.d[i];
            a += d[i] * d[i];
            h += oc[i] * d[i];
            cc += oc[i] * oc[i];
         end
         cc -= rr * rr;
         if (a > 0) begin
            hh = 128'(mag(h)) * 128'(mag(h));
            ac = 128'(a) * 128'(mag(cc));
            ok = 1;
            if (cc <= 0) disc = hh + ac;
            else if (ac <= hh) disc = hh - ac;
            else ok = 0;
            if (ok) begin
               s = root_floor(disc, 34);
               num = -h - longint'(s);
               if (num > 0) begin
                  td = (longint'(num) << FRAC) / a;
                  mx = 0;
                  for (int i = 0; i < 3; i++) begin
                     m = oc[i] * a + num * d[i];
                     neg[i] = m < 0;
                     mg[i] = mag(m);
                     if (mg[i] > mx) mx = mg[i];
                  end
                  if (mx == 0) begin
                     e.red = DEGEN_BYTE; e.green = DEGEN_BYTE; e.blue = DEGEN_BYTE;
                  end else begin
                     while (mx >= (64'd1 << 30)) begin
                        mx >>= 1;
                        for (int i = 0; i < 3; i++) mg[i] >>= 1;
                     end
                     while (mx < (64'd1 << NORM_TOP)) begin
                        mx <<= 1;
                        for (int i = 0; i < 3; i++) mg[i] <<= 1;
                     end
                     sum = 0;
                     for (int i = 0; i < 3; i++) sum += mg[i] * mg[i];
                     len = root_floor(128'(sum), 31);
                     for (int i = 0; i < 3; i++) begin
                        if (neg[i]) val = mg[i] >= len ? 0 : len - mg[i];
                        else val = len + (mg[i] > len ? len : mg[i]);
                        if (i == 0) e.red = to_byte(BYTE_SCALE * val, DEN_HIT * len);
                        else if (i == 1) e.green = to_byte(BYTE_SCALE * val, DEN_HIT * len);
                        else e.blue = to_byte(BYTE_SCALE * val, DEN_HIT * len);
                     end
                  end
                  e.hit = 1;
                  e.distance = td > 65535 ? 16'hFFFF : td[15:0];
                  done = 1;
               end
            end
         end
         if (!done) begin
            if (a > 0) begin
               lv = root_floor(128'(a) << 30, 31);
               yv = d[1] * 32768;
               if (yv > lv) yv = lv;
               if (yv < -lv) yv = -lv;
            end else begin
               lv = 1;
               yv = 0;
            end
            e.red = to_byte(BYTE_SCALE * (3 * lv - yv), DEN_RED * lv);
            e.green = to_byte(BYTE_SCALE * (17 * lv - 3 * yv), DEN_GREEN * lv);
            e.blue = SKY_BLUE;
            e.hit = 0;
            e.distance = 0;
         end
         expected_q.push_back(e);
      endfunction

      function void check(shade_type got);
         shade_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result beat");
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.red !== e.red) begin
            $error("red expected %0d actual %0d", e.red, got.red); errors++;
         end
         if (got.green !== e.green) begin
            $error("green expected %0d actual %0d", e.green, got.green); errors++;
         end
         if (got.blue !== e.blue) begin
            $error("blue expected %0d actual %0d", e.blue, got.blue); errors++;
         end
         if (got.hit !== e.hit) begin
            $error("hit expected %0d actual %0d", e.hit, got.hit); errors++;
         end
         if (got.distance !== e.distance) begin
            $error("hit_distance expected %0d actual %0d", e.distance, got.distance);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;

   shade_scoreboard sb = new();
   int idle_mode = 0;
   int rays_sent = 0;
   longint cycles = 0;

   ray_sphere_shade_unit u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (idle_mode == 0) rsp_tready <= $urandom_range(99) >= 69;
      else if (idle_mode == 1) rsp_tready <= $urandom_range(99) >= 17;
      else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      shade_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red = rsp_tdata[7:0];
         got.green = rsp_tdata[15:8];
         got.blue = rsp_tdata[23:16];
         got.distance = rsp_tdata[39:24];
         got.hit = rsp_tuser;
         sb.check(got);
      end
   end

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_ray(ray_type r);
      int idle_pct;
      idle_pct = (idle_mode == 0) ? 17 : ((idle_mode == 1) ? 69 : 0);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.d[2], r.d[1], r.d[0], r.o[2], r.o[1], r.o[0]};
      do @(posedge clock); while (!req_tready);
      sb.note(r);
      rays_sent++;
      idle_mode = rays_sent < 333 ? 0 : (rays_sent < 666 ? 1 : 2);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_sphere(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                             logic [15:0] rad);
      write_csr(CSR_CENTER_X, cx);
      write_csr(CSR_CENTER_Y, cy);
      write_csr(CSR_CENTER_Z, cz);
      write_csr(CSR_RADIUS, rad);
   endtask

   function automatic logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic ray_type mk(longint ox, longint oy, longint oz,
                                  longint dx, longint dy, longint dz);
      ray_type r;
      r.o[0] = sat16(ox); r.o[1] = sat16(oy); r.o[2] = sat16(oz);
      r.d[0] = sat16(dx); r.d[1] = sat16(dy); r.d[2] = sat16(dz);
      return r;
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      longint span, org, tgt;
      int shift;
      if ($urandom_range(99) < 35) begin
         for (int i = 0; i < 3; i++) begin
            r.o[i] = 16'($urandom);
            r.d[i] = 16'($urandom);
         end
      end else begin
         // aim near the sphere so most rays hit or graze it
         span = sb.radius + 64;
         shift = $urandom_range(3);
         for (int i = 0; i < 3; i++) begin
            org = $signed(16'($urandom)) >>> $urandom_range(3);
            tgt = longint'(sb.center[i]) + $urandom_range(2 * span) - span;
            r.o[i] = sat16(org);
            r.d[i] = sat16((tgt - org) >>> shift);
         end
      end
      return r;
   endfunction

   initial begin
      ray_type r;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default sphere at z = -1, radius 0.5
      send_ray(mk(0, 0, 0, 0, 0, 0));
      send_ray(mk(0, 0, 0, 0, 0, -4096));
      send_ray(mk(0, 0, 0, 0, 0, 4096));
      send_ray(mk(0, 0, -4096, 0, 0, -4096));
      send_ray(mk(2048, 0, 0, 0, 0, -4096));
      send_ray(mk(1024, 1024, 0, 0, 0, -4096));
      send_ray(mk(0, 0, 0, 0, 32767, 0));
      send_ray(mk(0, 0, 0, 0, -32768, 0));
      send_ray(mk(0, 0, 0, 32767, 32767, 32767));
      send_ray(mk(0, 0, 0, -32768, -32768, -32768));
      send_ray(mk(32767, 32767, 32767, -32768, -32768, -32768));
      send_ray(mk(-32768, -32768, -32768, 32767, 32767, 32767));
      send_ray(mk(0, 0, 0, 1, 0, 0));
      send_ray(mk(0, 0, 0, 0, 0, -1));
      send_ray(mk(0, 0, -8192, 0, 0, 4096));
      send_ray(mk(0, 0, 4096, 0, 0, -32768));

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: set_sphere(0, 0, -4096, 2048);
            1: set_sphere(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
            2: begin
               set_sphere(0, 0, -4096, 0);
               send_ray(mk(0, 0, 0, 0, 0, -4096));
               send_ray(mk(0, 0, 4096, 0, 0, -4096));
               send_ray(mk(0, 0, 0, 0, 0, -1));
            end
            3: set_sphere(16'h8000, 16'h7FFF, 16'h8000, 16'h0001);
            4: set_sphere(16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom_range(32767)));
            default: set_sphere(16'($urandom_range(8191)), 16'($urandom_range(8191)),
                                -16'sd8192, 16'($urandom_range(8192, 1024)));
         endcase
         for (int k = 0; k < 165; k++) begin
            r = random_ray();
            send_ray(r);
            if (phase == 2 && k == 80) drain();
         end
      end
      drain();
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
src/rss_pkg.sv
src/rss_sqrt_pipe.sv
src/rss_div_pipe.sv
src/ray_sphere_shade_unit.sv
verif/tb_ray_sphere_shade_unit.sv
